[rtl/rlefb_pkg.sv]
`default_nettype none

package rlefb_pkg;

  // command class decided by the front part
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_EOF  = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_WRITE    = 3'd0;
  localparam logic [2:0] KIND_ACCEPT   = 3'd1;
  localparam logic [2:0] KIND_IDLE     = 3'd2;
  localparam logic [2:0] KIND_BUSY     = 3'd3;
  localparam logic [2:0] KIND_FINISHED = 3'd4;
  localparam logic [2:0] KIND_ERR_A    = 3'd5;
  localparam logic [2:0] KIND_ERR_B    = 3'd6;

  // stop status
  localparam logic [1:0] STOP_RUN   = 2'd0;
  localparam logic [1:0] STOP_FIN   = 2'd1;
  localparam logic [1:0] STOP_ERR_A = 2'd2;
  localparam logic [1:0] STOP_ERR_B = 2'd3;

  // register indexes
  localparam logic CFG_MARKER_A = 1'b0;
  localparam logic CFG_MARKER_B = 1'b1;

  localparam logic [7:0] MARKER_A_RESET = 8'd255;
  localparam logic [7:0] MARKER_B_RESET = 8'd254;

  localparam logic [15:0] SHORT_RUN_BIAS = 16'd4;

  localparam int ADDR_W = 14;
  localparam int POS_W  = 15;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       hit_a;
    logic       hit_b;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/rlefb_if.sv]
`default_nettype none

interface rlefb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface rlefb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [13:0] write_address;
  logic [7:0]  pixel_byte;
  logic        last_write;

  modport source (output valid, output kind, output write_address, output pixel_byte,
                  output last_write, input ready);
  modport sink (input valid, input kind, input write_address, input pixel_byte,
                input last_write, output ready);
endinterface

`default_nettype wire

[rtl/rlefb_front.sv]
`default_nettype none

module rlefb_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic           cfg_index,
  input  wire logic [7:0]     cfg_wr_data,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_opcode,
  input  wire logic [7:0]     in_data_byte,
  output logic                push_valid,
  input  wire logic           push_ready,
  output rlefb_pkg::cmd_t     push_cmd
);
  import rlefb_pkg::*;

  logic [7:0] marker_a_r;
  logic [7:0] marker_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_a_r <= MARKER_A_RESET;
      marker_b_r <= MARKER_B_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MARKER_A: marker_a_r <= cfg_wr_data;
        CFG_MARKER_B: marker_b_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    push_cmd.data_byte = in_data_byte;
    push_cmd.hit_a     = (in_data_byte == marker_a_r);
    push_cmd.hit_b     = (in_data_byte == marker_b_r);
    case (in_opcode)
      CMD_DATA: push_cmd.op = CMD_DATA;
      CMD_STEP: push_cmd.op = CMD_STEP;
      CMD_EOF:  push_cmd.op = CMD_EOF;
      default:  push_cmd.op = CMD_NOP;
    endcase
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

`default_nettype wire

[rtl/rlefb_queue.sv]
`default_nettype none

module rlefb_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire rlefb_pkg::cmd_t push_cmd,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output rlefb_pkg::cmd_t      pop_cmd
);
  import rlefb_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

[rtl/rlefb_back.sv]
`default_nettype none

module rlefb_back #(
  parameter int IMAGE_BYTES = 16000,
  parameter int ROW_BYTES   = 80,
  parameter int BANK_OFFSET = 8192
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire rlefb_pkg::cmd_t pop_cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [2:0]           out_kind,
  output logic [13:0]          out_write_address,
  output logic [7:0]           out_pixel_byte,
  output logic                 out_last_write
);
  import rlefb_pkg::*;

  localparam int COL_W = $clog2(ROW_BYTES + 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(ROW_BYTES - 1);
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(IMAGE_BYTES - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(ROW_BYTES);
  localparam logic [ADDR_W-1:0] BANK_STEP = ADDR_W'(BANK_OFFSET);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_A_CNT  = 3'd1;
  localparam logic [2:0] PH_A_VAL  = 3'd2;
  localparam logic [2:0] PH_B_LO   = 3'd3;
  localparam logic [2:0] PH_B_HI   = 3'd4;
  localparam logic [2:0] PH_B_VAL  = 3'd5;

  logic [2:0]        phase_r,     phase_nxt;
  logic [7:0]        count_low_r, count_low_nxt;
  logic [15:0]       run_left_r,  run_left_nxt;
  logic [7:0]        run_value_r, run_value_nxt;
  logic [COL_W-1:0]  col_r,       col_nxt;
  logic              odd_row_r,   odd_row_nxt;
  logic [ADDR_W-1:0] row_base_r,  row_base_nxt;
  logic [POS_W-1:0]  pos_r,       pos_nxt;
  logic [1:0]        stop_r,      stop_nxt;

  logic              out_valid_r;
  logic [2:0]        kind_r,  kind_nxt;
  logic [ADDR_W-1:0] addr_r,  addr_nxt;
  logic [7:0]        pix_r,   pix_nxt;
  logic              last_r,  last_nxt;

  logic fire;
  logic pending;

  assign pop_ready = !out_valid_r || out_ready;
  assign fire      = pop_valid && pop_ready;
  assign pending   = (phase_r == PH_IDLE) && (run_left_r != 16'd0);

  always_comb begin
    phase_nxt     = phase_r;
    count_low_nxt = count_low_r;
    run_left_nxt  = run_left_r;
    run_value_nxt = run_value_r;
    col_nxt       = col_r;
    odd_row_nxt   = odd_row_r;
    row_base_nxt  = row_base_r;
    pos_nxt       = pos_r;
    stop_nxt      = stop_r;
    kind_nxt      = KIND_IDLE;
    addr_nxt      = '0;
    pix_nxt       = '0;
    last_nxt      = 1'b0;

    if (stop_r != STOP_RUN) begin
      case (stop_r)
        STOP_FIN:   kind_nxt = KIND_FINISHED;
        STOP_ERR_A: kind_nxt = KIND_ERR_A;
        default:    kind_nxt = KIND_ERR_B;
      endcase
    end else begin
      case (pop_cmd.op)
        CMD_DATA: begin
          if (pending) begin
            kind_nxt = KIND_BUSY;
          end else begin
            kind_nxt = KIND_ACCEPT;
            case (phase_r)
              PH_IDLE: begin
                if (pop_cmd.hit_a) begin
                  phase_nxt = PH_A_CNT;
                end else if (pop_cmd.hit_b) begin
                  phase_nxt = PH_B_LO;
                end else begin
                  run_left_nxt  = 16'd1;
                  run_value_nxt = pop_cmd.data_byte;
                end
              end
              PH_A_CNT: begin
                count_low_nxt = pop_cmd.data_byte;
                phase_nxt     = PH_A_VAL;
              end
              PH_A_VAL: begin
                run_left_nxt  = {8'd0, count_low_r} + SHORT_RUN_BIAS;
                run_value_nxt = pop_cmd.data_byte;
                phase_nxt     = PH_IDLE;
              end
              PH_B_LO: begin
                count_low_nxt = pop_cmd.data_byte;
                phase_nxt     = PH_B_HI;
              end
              PH_B_HI: begin
                run_left_nxt = {pop_cmd.data_byte, count_low_r};
                phase_nxt    = PH_B_VAL;
              end
              default: begin
                run_value_nxt = pop_cmd.data_byte;
                phase_nxt     = PH_IDLE;
              end
            endcase
          end
        end
        CMD_STEP: begin
          if (pending) begin
            kind_nxt     = KIND_WRITE;
            addr_nxt     = row_base_r + (odd_row_r ? BANK_STEP : '0) + ADDR_W'(col_r);
            pix_nxt      = run_value_r;
            run_left_nxt = run_left_r - 16'd1;
            // row and column counters stand in for the divide by row width
            if (col_r == COL_LAST) begin
              col_nxt     = '0;
              odd_row_nxt = ~odd_row_r;
              if (odd_row_r) row_base_nxt = row_base_r + ROW_STEP;
            end else begin
              col_nxt = col_r + COL_W'(1);
            end
            pos_nxt = pos_r + POS_W'(1);
            if (pos_r == POS_LAST) begin
              last_nxt     = 1'b1;
              stop_nxt     = STOP_FIN;
              run_left_nxt = 16'd0;
            end
          end else begin
            kind_nxt = KIND_IDLE;
          end
        end
        CMD_EOF: begin
          if (pending) begin
            kind_nxt = KIND_BUSY;
          end else if (phase_r == PH_IDLE) begin
            kind_nxt = KIND_FINISHED;
            stop_nxt = STOP_FIN;
          end else if (phase_r == PH_A_CNT || phase_r == PH_A_VAL) begin
            kind_nxt = KIND_ERR_A;
            stop_nxt = STOP_ERR_A;
          end else begin
            kind_nxt = KIND_ERR_B;
            stop_nxt = STOP_ERR_B;
          end
        end
        default: kind_nxt = KIND_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_low_r <= '0;
      run_left_r  <= '0;
      run_value_r <= '0;
      col_r       <= '0;
      odd_row_r   <= 1'b0;
      row_base_r  <= '0;
      pos_r       <= '0;
      stop_r      <= STOP_RUN;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      count_low_r <= count_low_nxt;
      run_left_r  <= run_left_nxt;
      run_value_r <= run_value_nxt;
      col_r       <= col_nxt;
      odd_row_r   <= odd_row_nxt;
      row_base_r  <= row_base_nxt;
      pos_r       <= pos_nxt;
      stop_r      <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind_r <= kind_nxt;
      addr_r <= addr_nxt;
      pix_r  <= pix_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_write_address = addr_r;
  assign out_pixel_byte    = pix_r;
  assign out_last_write    = last_r;

endmodule

`default_nettype wire

[rtl/rle_unpack_to_interleaved_framebuffer_unit.sv]
`default_nettype none

// channel  | dir | handshake      | payload
// in_ch    | in  | valid / ready  | opcode[1:0], data_byte[7:0]
// out_ch   | out | valid / ready  | kind[2:0], write_address[13:0], pixel_byte[7:0], last_write
// cfg      | in  | cfg_wr_en      | cfg_index (0 marker a, 1 marker b), cfg_wr_data[7:0]
//
// one request per cycle sustained while out_ch.ready stays high, one result per request
// each result passes through a queue slot on input accept, then the result register
// the result register is the only stage that waits on out_ch.ready; a 2-entry queue
//   in front of the executing part takes two more requests while a result is held,
//   then in_ch.ready drops
// synchronous active-low reset: markers back to 255 / 254, parse state, counters cleared

module rle_unpack_to_interleaved_framebuffer_unit #(
  parameter int IMAGE_BYTES = 16000,
  parameter int ROW_BYTES   = 80,
  parameter int BANK_OFFSET = 8192
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wr_data,
  rlefb_in_if.sink        in_ch,
  rlefb_out_if.source     out_ch
);
  import rlefb_pkg::*;

  // front to queue
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;

  // queue to back
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // decode opcode and compare against both markers
  rlefb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_opcode    (in_ch.opcode),
    .in_data_byte (in_ch.data_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  // decouples accept from execution
  rlefb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // parse state, run counter, interleaved address generation, result register
  rlefb_back #(
    .IMAGE_BYTES (IMAGE_BYTES),
    .ROW_BYTES   (ROW_BYTES),
    .BANK_OFFSET (BANK_OFFSET)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_cmd           (pop_cmd),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_kind          (out_ch.kind),
    .out_write_address (out_ch.write_address),
    .out_pixel_byte    (out_ch.pixel_byte),
    .out_last_write    (out_ch.last_write)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

import rlefb_pkg::*;

typedef struct packed {
  logic [2:0]  kind;
  logic [13:0] addr;
  logic [7:0]  pixel;
  logic        last;
} fb_result_t;

typedef enum logic [2:0] {
  PH_LEAD,
  PH_A_COUNT,
  PH_A_VALUE,
  PH_B_LOW,
  PH_B_HIGH,
  PH_B_VALUE
} parse_phase_e;

class framebuffer_scoreboard;
  localparam int IMAGE_BYTES = 16000;
  localparam int ROW_BYTES   = 80;
  localparam int BANK_OFFSET = 8192;

  logic [7:0]   code_a;
  logic [7:0]   code_b;
  parse_phase_e phase;
  logic [7:0]   count_lo;
  logic [15:0]  run_left;
  logic [7:0]   run_val;
  int           col;
  int           row;
  logic [1:0]   stop;
  fb_result_t   results_due[$];
  int           fail_count;

  function new();
    code_a     = MARKER_A_RESET;
    code_b     = MARKER_B_RESET;
    phase      = PH_LEAD;
    count_lo   = '0;
    run_left   = '0;
    run_val    = '0;
    col        = 0;
    row        = 0;
    stop       = STOP_RUN;
    fail_count = 0;
  endfunction

  function void set_marker(logic idx, logic [7:0] value);
    if (idx == CFG_MARKER_A) code_a = value;
    else code_b = value;
  endfunction

  function bit run_pending();
    return (phase == PH_LEAD) && (run_left != 0);
  endfunction

  function int bytes_written();
    return row * ROW_BYTES + col;
  endfunction

  function int pending_count();
    return results_due.size();
  endfunction

  // marker a is tested first, so it wins when both codes match
  function void absorb_byte(logic [7:0] b);
    case (phase)
      PH_LEAD: begin
        if (b == code_a) phase = PH_A_COUNT;
        else if (b == code_b) phase = PH_B_LOW;
        else begin
          run_left = 16'd1;
          run_val  = b;
        end
      end
      PH_A_COUNT: begin
        count_lo = b;
        phase    = PH_A_VALUE;
      end
      PH_A_VALUE: begin
        run_left = {8'd0, count_lo} + SHORT_RUN_BIAS;
        run_val  = b;
        phase    = PH_LEAD;
      end
      PH_B_LOW: begin
        count_lo = b;
        phase    = PH_B_HIGH;
      end
      PH_B_HIGH: begin
        run_left = {b, count_lo};
        phase    = PH_B_VALUE;
      end
      default: begin
        run_val = b;
        phase   = PH_LEAD;
      end
    endcase
  endfunction

  // odd rows go to the upper bank, each bank row is ROW_BYTES wide
  function fb_result_t emit_pixel();
    fb_result_t r;
    r       = '0;
    r.kind  = KIND_WRITE;
    r.addr  = 14'(ROW_BYTES * (row / 2) + (row % 2) * BANK_OFFSET + col);
    r.pixel = run_val;
    run_left = run_left - 16'd1;
    col++;
    if (col >= ROW_BYTES) begin
      col = 0;
      row++;
    end
    if (row * ROW_BYTES + col >= IMAGE_BYTES) begin
      r.last   = 1'b1;
      stop     = STOP_FIN;
      run_left = '0;
    end
    return r;
  endfunction

  function fb_result_t decode_request(logic [1:0] op, logic [7:0] b);
    fb_result_t r;
    bit         busy;
    r    = '0;
    busy = run_pending();
    if (stop != STOP_RUN) begin
      case (stop)
        STOP_FIN:   r.kind = KIND_FINISHED;
        STOP_ERR_A: r.kind = KIND_ERR_A;
        default:    r.kind = KIND_ERR_B;
      endcase
      return r;
    end
    case (op)
      CMD_DATA: begin
        if (busy) r.kind = KIND_BUSY;
        else begin
          absorb_byte(b);
          r.kind = KIND_ACCEPT;
        end
      end
      CMD_STEP: begin
        if (busy) r = emit_pixel();
        else r.kind = KIND_IDLE;
      end
      CMD_EOF: begin
        if (busy) r.kind = KIND_BUSY;
        else if (phase == PH_LEAD) begin
          stop   = STOP_FIN;
          r.kind = KIND_FINISHED;
        end else if (phase == PH_A_COUNT || phase == PH_A_VALUE) begin
          stop   = STOP_ERR_A;
          r.kind = KIND_ERR_A;
        end else begin
          stop   = STOP_ERR_B;
          r.kind = KIND_ERR_B;
        end
      end
      default: r.kind = KIND_IDLE;
    endcase
    return r;
  endfunction

  function void note_request(logic [1:0] op, logic [7:0] b);
    results_due.push_back(decode_request(op, b));
  endfunction

  function void check_result(fb_result_t got);
    fb_result_t want;
    if (results_due.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected result: kind %0d addr %0d pixel 0x%02h last %0d",
                 got.kind, got.addr, got.pixel, got.last);
      fail_count++;
      return;
    end
    want = results_due.pop_front();
    if (got.kind !== want.kind || got.addr !== want.addr ||
        got.pixel !== want.pixel || got.last !== want.last) begin
      if (fail_count < 10)
        $display({"result mismatch: expected kind %0d addr %0d pixel 0x%02h last %0d,",
                  " got kind %0d addr %0d pixel 0x%02h last %0d"},
                 want.kind, want.addr, want.pixel, want.last,
                 got.kind, got.addr, got.pixel, got.last);
      fail_count++;
    end
  endfunction
endclass

module testbench;

  // the slowest legal run is about 17k requests each waiting out a long hold
  localparam int CYCLE_LIMIT    = 6000000;
  localparam int PHASE_REQUESTS = 140;
  localparam int DRAIN_LIMIT    = 2000;

  typedef enum int {RX_STEADY, RX_COIN, RX_EVERY_THIRD, RX_MOSTLY, RX_HOLD} rx_mode_e;
  typedef enum int {END_AT_EOF, END_IN_MARKER_A, END_IN_MARKER_B, END_BY_OVERFLOW} end_kind_e;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [7:0] cfg_wr_data;

  rlefb_in_if  in_if();
  rlefb_out_if out_if();

  framebuffer_scoreboard sb;

  int items_sent;
  int burst_left;
  int cycle_count;

  rle_unpack_to_interleaved_framebuffer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_if),
    .out_ch      (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // every accepted result goes straight to the scoreboard
  always @(posedge clk) begin : watch_results
    fb_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind  = out_if.kind;
      got.addr  = out_if.write_address;
      got.pixel = out_if.pixel_byte;
      got.last  = out_if.last_write;
      sb.check_result(got);
    end
  end

  // receiver pacing: stretches of different stall patterns, the third stretch is
  // always a long hold so the internal queue fills and in_ch.ready drops
  initial begin : rx_pacing
    rx_mode_e mode;
    int       span;
    int       stretch;
    out_if.ready <= 1'b0;
    stretch = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stretch == 2 || $urandom_range(0, 11) == 0) begin
        mode = RX_HOLD;
        span = $urandom_range(40, 120);
      end else begin
        mode = rx_mode_e'($urandom_range(0, 3));
        span = $urandom_range(10, 80);
      end
      stretch++;
      for (int i = 0; i < span; i++) begin
        case (mode)
          RX_STEADY:      out_if.ready <= 1'b1;
          RX_COIN:        out_if.ready <= 1'($urandom_range(0, 1));
          RX_EVERY_THIRD: out_if.ready <= (i % 3 == 0);
          RX_MOSTLY:      out_if.ready <= ($urandom_range(0, 3) != 0);
          default:        out_if.ready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  // one request; the sender idles between bursts of random length, and valid
  // stays high from one request to the next inside a burst
  task automatic send_request(input logic [1:0] op, input logic [7:0] b);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.data_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_request(op, b);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(CMD_DATA, b);
  endtask

  // stray request in the middle of a marker sequence: step or nop, both idle there
  task automatic maybe_noise(input int pct);
    if ($urandom_range(0, 99) < pct)
      send_request($urandom_range(0, 1) ? CMD_STEP : CMD_NOP, 8'($urandom_range(0, 255)));
  endtask

  // step out the pending run; noise while pending is refused as busy or ignored
  task automatic drain_run(input int noise_pct);
    int r;
    while (sb.run_pending()) begin
      r = $urandom_range(0, 99);
      if (r >= noise_pct) send_request(CMD_STEP, 8'($urandom_range(0, 255)));
      else begin
        case (r % 3)
          0:       send_request(CMD_DATA, 8'($urandom_range(0, 255)));
          1:       send_request(CMD_EOF, 8'($urandom_range(0, 255)));
          default: send_request(CMD_NOP, 8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  task automatic send_literal();
    logic [7:0] lit;
    do lit = 8'($urandom_range(0, 255));
    while (lit == sb.code_a || lit == sb.code_b);
    send_byte(lit);
  endtask

  // one well-formed token (literal, marker a or marker b) with random content,
  // then its run; with equal codes a marker b sequence decodes as marker a
  task automatic send_token(input int noise_pct);
    int          pick;
    int          r;
    logic [15:0] cnt;
    pick = $urandom_range(0, 9);
    r    = $urandom_range(0, 99);
    if (pick < 4) send_literal();
    else if (pick < 7) begin
      cnt = (r < 80) ? 16'($urandom_range(0, 12)) :
            (r < 95) ? 16'($urandom_range(13, 60)) : 16'($urandom_range(0, 255));
      send_byte(sb.code_a);
      maybe_noise(noise_pct);
      send_byte(cnt[7:0]);
      maybe_noise(noise_pct);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      cnt = (r < 10) ? 16'd0 :
            (r < 85) ? 16'($urandom_range(1, 40)) :
            (r < 95) ? 16'($urandom_range(41, 255)) : 16'($urandom_range(256, 300));
      send_byte(sb.code_b);
      maybe_noise(noise_pct);
      send_byte(cnt[7:0]);
      maybe_noise(noise_pct);
      send_byte(cnt[15:8]);
      maybe_noise(noise_pct);
      send_byte(8'($urandom_range(0, 255)));
    end
    drain_run(noise_pct);
  endtask

  // mostly tokens, the rest idle steps and nop requests
  task automatic random_phase(input int count);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 75) send_token(12);
      else if (r < 88) send_request(CMD_STEP, 8'($urandom_range(0, 255)));
      else send_request(CMD_NOP, 8'($urandom_range(0, 255)));
    end
  endtask

  // wait for every outstanding result, then let the inputs stay quiet before a write
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers in back-to-back cycles, enable held high across them
  task automatic program_markers(input logic [7:0] a, input logic [7:0] b);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_MARKER_A;
    cfg_wr_data <= a;
    @(posedge clk);
    sb.set_marker(CFG_MARKER_A, a);
    cfg_index   <= CFG_MARKER_B;
    cfg_wr_data <= b;
    @(posedge clk);
    sb.set_marker(CFG_MARKER_B, b);
    cfg_wr_en   <= 1'b0;
  endtask

  // walk the image up to target bytes with long runs so every row and both
  // banks are written; codes are distinct here
  task automatic fill_image(input int target);
    int          room;
    int          pick;
    logic [15:0] cnt;
    while (sb.bytes_written() < target) begin
      room = target - sb.bytes_written();
      pick = $urandom_range(0, 9);
      if (pick == 0 || room < 4) send_literal();
      else if (pick < 3) begin
        cnt = 16'($urandom_range(0, (room - 4 > 255) ? 255 : room - 4));
        send_byte(sb.code_a);
        send_byte(cnt[7:0]);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        cnt = 16'($urandom_range(1, (room < 4095) ? room : 4095));
        send_byte(sb.code_b);
        send_byte(cnt[7:0]);
        send_byte(cnt[15:8]);
        send_byte(8'($urandom_range(0, 255)));
      end
      drain_run(3);
    end
  endtask

  // one way to stop the decoder, then requests that must all echo the stop
  task automatic finish_stream();
    end_kind_e how;
    how = end_kind_e'($urandom_range(0, 3));
    case (how)
      END_AT_EOF: send_request(CMD_EOF, 8'($urandom_range(0, 255)));
      END_IN_MARKER_A: begin
        send_byte(sb.code_a);
        if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
        send_request(CMD_EOF, 8'($urandom_range(0, 255)));
      end
      END_IN_MARKER_B: begin
        send_byte(sb.code_b);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        send_request(CMD_EOF, 8'($urandom_range(0, 255)));
      end
      default: begin
        // run far longer than the space left: clipped at the last byte
        send_byte(sb.code_b);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(64, 255)));
        send_byte(8'($urandom_range(0, 255)));
        drain_run(5);
      end
    endcase
    repeat (12) send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    logic [7:0] last_a;
    logic [7:0] last_b;
    int         waited;

    sb         = new();
    items_sent = 0;
    burst_left = 0;

    in_if.valid     <= 1'b0;
    in_if.opcode    <= CMD_NOP;
    in_if.data_byte <= 8'd0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= CFG_MARKER_A;
    cfg_wr_data     <= 8'd0;
    rst_n           <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset codes 255 / 254
    // step with no run, and the unused opcode: both idle
    send_request(CMD_STEP, 8'h00);
    send_request(CMD_NOP, 8'hFF);
    // literal zero, then data and end of file while its run is pending: busy
    send_byte(8'h00);
    send_byte(8'h11);
    send_request(CMD_EOF, 8'h00);
    send_request(CMD_STEP, 8'hFF);
    // highest byte that is still a literal
    send_byte(8'hFD);
    send_request(CMD_STEP, 8'h00);
    // marker a with count zero gives four copies, a step mid-marker is idle
    send_byte(MARKER_A_RESET);
    send_request(CMD_STEP, 8'h00);
    send_byte(8'h00);
    send_byte(8'hAA);
    drain_run(0);
    // zero-length marker b run: accepted, nothing written
    send_byte(MARKER_B_RESET);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h55);
    send_request(CMD_STEP, 8'h00);
    // short marker b run
    send_byte(MARKER_B_RESET);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h7F);
    drain_run(0);

    random_phase(PHASE_REQUESTS);

    // extremes of the codes
    settle();
    program_markers(8'h00, 8'hFF);
    random_phase(PHASE_REQUESTS);

    // equal codes, marker a takes precedence
    settle();
    program_markers(8'h5A, 8'h5A);
    random_phase(PHASE_REQUESTS);

    settle();
    program_markers(8'hFF, 8'h00);
    random_phase(PHASE_REQUESTS);

    // random distinct codes for the rest of the run
    settle();
    last_a = 8'($urandom_range(0, 255));
    do last_b = 8'($urandom_range(0, 255));
    while (last_b == last_a);
    program_markers(last_a, last_b);
    random_phase(PHASE_REQUESTS);

    // nearly fill the image, then stop it one way or another
    fill_image(16000 - $urandom_range(1, 100));
    finish_stream();
    in_if.valid <= 1'b0;

    waited = 0;
    while (sb.pending_count() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending_count() != 0) begin
      $display("%0d expected results never arrived", sb.pending_count());
      sb.fail_count++;
    end

    if (sb.fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
